/* src/rwc_pkg.sv */
// Shared types and constants for the raycast wall column texturer.
// Used by the divider, datapath, controller and top level; no dependencies.
package rwc_pkg;

	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned TEX_DIM_W = 11;
	localparam int unsigned TXL_W     = 10;
	localparam int unsigned ROW_W     = 12;
	localparam int unsigned COL_W     = 11;
	localparam int unsigned DIST_W    = 24;
	localparam int unsigned DVS_W     = 24;
	localparam int unsigned HGT_W     = 16;
	localparam int unsigned HH_W      = 15;
	localparam int unsigned QUO_W     = 27;
	localparam int unsigned POS_W     = 26;
	localparam int unsigned PROD_W    = HH_W + QUO_W;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned SEL_W     = 2;

	localparam logic [TEX_DIM_W-1:0] TEX_DIM_MAX   = 11'd1024;
	localparam logic [TEX_DIM_W-1:0] TEX_DIM_RESET = 11'd64;
	localparam logic [HGT_W-1:0]     HGT_MAX       = 16'hFFFF;

	localparam logic [SEL_W-1:0] TEX_NORTH = 2'd0;
	localparam logic [SEL_W-1:0] TEX_SOUTH = 2'd1;
	localparam logic [SEL_W-1:0] TEX_EAST  = 2'd2;
	localparam logic [SEL_W-1:0] TEX_WEST  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_NORTH_H = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOUTH_H = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EAST_H  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WEST_H  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NORTH_W = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SOUTH_W = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_EAST_W  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_WEST_W  = 3'd7;

	// Operand and destination choice for the shared divider.
	typedef enum logic [2:0] {
		DOP_HEIGHT  = 3'd0,
		DOP_TSTEP   = 3'd1,
		DOP_POS     = 3'd2,
		DOP_U       = 3'd3,
		DOP_PIXPOS  = 3'd4,
		DOP_PIXSTEP = 3'd5
	} div_op_t;

	typedef struct packed {
		logic    load_start;
		logic    div_start;
		logic    div_capture;
		div_op_t div_op;
		logic    mul_load;
		logic    emit;
	} rwc_cmd_t;

	typedef struct packed {
		logic active;
		logic div_done;
		logic u_stale;
		logic pos_big;
		logic step_big;
		logic out_free;
	} rwc_status_t;

	// A texture size of zero acts as one, and anything above 1024 acts as 1024.
	function automatic logic [TEX_DIM_W-1:0] clamp_size(input logic [TEX_DIM_W-1:0] v);
		logic [TEX_DIM_W-1:0] r;
		if (v == '0) begin
			r = TEX_DIM_W'(1);
		end else if (v > TEX_DIM_MAX) begin
			r = TEX_DIM_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* src/rwc_divider.sv */
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// Depends on rwc_pkg for the divisor width.
module rwc_divider #(
	parameter int DIV_W = 27
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DIV_W-1:0]          dividend,
	input  logic [rwc_pkg::DVS_W-1:0] divisor,
	output logic                      done,
	output logic [DIV_W-1:0]          quot,
	output logic [rwc_pkg::DVS_W-1:0] rem
);
	import rwc_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] acc_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, acc_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = acc_q;
	assign rem  = rem_q;

endmodule

/* src/rwc_datapath.sv */
// Datapath: texture size registers, column state, the shared divider, the
// position multiplier and the output register. Depends on rwc_pkg and rwc_divider.
module rwc_datapath #(
	parameter int SCREEN_HEIGHT = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [rwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rwc_pkg::TEX_DIM_W-1:0] cfg_data,
	input  logic [rwc_pkg::COL_W-1:0]     column_x,
	input  logic [rwc_pkg::DIST_W-1:0]    wall_distance,
	input  logic                          hit_side,
	input  logic                          ray_dir_x_positive,
	input  logic                          ray_dir_y_positive,
	input  rwc_pkg::rwc_cmd_t             cmd,
	output rwc_pkg::rwc_status_t          status,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [rwc_pkg::COL_W-1:0]     screen_x,
	output logic [rwc_pkg::ROW_W-1:0]     screen_y,
	output logic [rwc_pkg::SEL_W-1:0]     texture_select,
	output logic [rwc_pkg::TXL_W-1:0]     texel_u,
	output logic [rwc_pkg::TXL_W-1:0]     texel_v,
	output logic                          last_pixel
);
	import rwc_pkg::*;

	localparam int SHW   = $clog2(SCREEN_HEIGHT + 1) + FRAC_W;
	localparam int DIV_W = (SHW > QUO_W) ? SHW : QUO_W;
	localparam logic [DIV_W-1:0] SH_DIVIDEND = DIV_W'(SCREEN_HEIGHT) << FRAC_W;
	localparam logic [HH_W:0]    HALF        = (HH_W + 1)'(SCREEN_HEIGHT / 2);
	localparam logic [HH_W:0]    ROW_MAX     = (HH_W + 1)'(SCREEN_HEIGHT - 1);

	logic [TEX_DIM_W-1:0] tex_h_q [4];
	logic [TEX_DIM_W-1:0] tex_w_q [4];

	logic                 active_q;
	logic                 out_valid_q;
	logic [COL_W-1:0]     col_q;
	logic [DIST_W-1:0]    dist_q;
	logic [SEL_W-1:0]     tex_q;
	logic [HGT_W-1:0]     height_q;
	logic [QUO_W-1:0]     q_q;
	logic [PROD_W-1:0]    prod_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     step_q;
	logic [TXL_W-1:0]     u_q;
	logic [TEX_DIM_W-1:0] u_tw_q;
	logic [ROW_W-1:0]     row_q;
	logic [ROW_W-1:0]     end_q;

	logic [COL_W-1:0]     screen_x_q;
	logic [ROW_W-1:0]     screen_y_q;
	logic [SEL_W-1:0]     texture_select_q;
	logic [TXL_W-1:0]     texel_u_q;
	logic [TXL_W-1:0]     texel_v_q;
	logic                 last_pixel_q;

	logic [SEL_W-1:0]     sel_in;
	logic [TEX_DIM_W-1:0] th;
	logic [TEX_DIM_W-1:0] tw;
	logic [DIV_W-1:0]     div_dividend;
	logic [DVS_W-1:0]     div_divisor;
	logic                 div_done;
	logic [DIV_W-1:0]     div_quot;
	logic [DVS_W-1:0]     div_rem;
	logic [HGT_W-1:0]     height_new;
	logic [HH_W:0]        hh;
	logic [HH_W:0]        end_sum;
	logic [ROW_W-1:0]     start_row;
	logic [ROW_W-1:0]     end_row;
	logic [HH_W-1:0]      offset;
	logic [TEX_DIM_W-1:0] q_int;
	logic [TEX_DIM_W-1:0] step_int;
	logic [POS_W:0]       pos_sum;
	logic [POS_W:0]       modulus;
	logic [POS_W:0]       pos_wrap;
	logic                 last;
	logic                 out_free;

	always_comb begin
		if (!hit_side) begin
			sel_in = ray_dir_x_positive ? TEX_EAST : TEX_WEST;
		end else begin
			sel_in = ray_dir_y_positive ? TEX_SOUTH : TEX_NORTH;
		end
	end

	assign th = clamp_size(tex_h_q[tex_q]);
	assign tw = clamp_size(tex_w_q[tex_q]);

	always_comb begin
		case (cmd.div_op)
			DOP_HEIGHT: begin
				div_dividend = SH_DIVIDEND;
				div_divisor  = dist_q;
			end
			DOP_TSTEP: begin
				div_dividend = DIV_W'({th, {FRAC_W{1'b0}}});
				div_divisor  = DVS_W'(height_q);
			end
			DOP_POS: begin
				div_dividend = DIV_W'(prod_q[PROD_W-1:FRAC_W]);
				div_divisor  = DVS_W'(th);
			end
			DOP_U: begin
				div_dividend = DIV_W'(col_q);
				div_divisor  = DVS_W'(tw);
			end
			DOP_PIXPOS: begin
				div_dividend = DIV_W'(pos_q[POS_W-1:FRAC_W]);
				div_divisor  = DVS_W'(th);
			end
			DOP_PIXSTEP: begin
				div_dividend = DIV_W'(step_q[POS_W-1:FRAC_W]);
				div_divisor  = DVS_W'(th);
			end
			default: begin
				div_dividend = '0;
				div_divisor  = '0;
			end
		endcase
	end

	rwc_divider #(
		.DIV_W (DIV_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// A zero distance divides by zero, which yields all ones and saturates here.
	always_comb begin
		if (div_quot > DIV_W'(HGT_MAX)) begin
			height_new = HGT_MAX;
		end else if (div_quot == '0) begin
			height_new = HGT_W'(1);
		end else begin
			height_new = div_quot[HGT_W-1:0];
		end
	end

	// Wall rows around the screen center, clamped to the screen.
	always_comb begin
		hh        = {1'b0, height_q[HGT_W-1:1]};
		end_sum   = HALF + hh;
		start_row = (hh < HALF) ? ROW_W'(HALF - hh) : '0;
		end_row   = (end_sum > ROW_MAX) ? ROW_W'(ROW_MAX) : ROW_W'(end_sum);
		offset    = (hh > HALF) ? HH_W'(hh - HALF) : '0;
	end

	// The integer part of the step never exceeds the texture height.
	assign q_int    = q_q[QUO_W-1:FRAC_W];
	assign step_int = (q_int >= th) ? (q_int - th) : q_int;

	assign modulus  = {th, {FRAC_W{1'b0}}};
	assign pos_sum  = {1'b0, pos_q} + {1'b0, step_q};
	assign pos_wrap = (pos_sum >= modulus) ? (pos_sum - modulus) : pos_sum;
	assign last     = (row_q == end_q);
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				tex_h_q[i] <= TEX_DIM_RESET;
				tex_w_q[i] <= TEX_DIM_RESET;
			end
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_NORTH_H: tex_h_q[TEX_NORTH] <= cfg_data;
				CFG_SOUTH_H: tex_h_q[TEX_SOUTH] <= cfg_data;
				CFG_EAST_H:  tex_h_q[TEX_EAST]  <= cfg_data;
				CFG_WEST_H:  tex_h_q[TEX_WEST]  <= cfg_data;
				CFG_NORTH_W: tex_w_q[TEX_NORTH] <= cfg_data;
				CFG_SOUTH_W: tex_w_q[TEX_SOUTH] <= cfg_data;
				CFG_EAST_W:  tex_w_q[TEX_EAST]  <= cfg_data;
				CFG_WEST_W:  tex_w_q[TEX_WEST]  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mul_load) begin
				active_q <= 1'b1;
			end else if (cmd.emit && last) begin
				active_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_start) begin
			col_q  <= column_x;
			dist_q <= wall_distance;
			tex_q  <= sel_in;
		end
		if (cmd.div_capture) begin
			case (cmd.div_op)
				DOP_HEIGHT:  height_q <= height_new;
				DOP_TSTEP:   q_q <= div_quot[QUO_W-1:0];
				DOP_POS:     pos_q <= {div_rem[TXL_W-1:0], prod_q[FRAC_W-1:0]};
				DOP_U: begin
					u_q    <= div_rem[TXL_W-1:0];
					u_tw_q <= tw;
				end
				DOP_PIXPOS:  pos_q[POS_W-1:FRAC_W] <= div_rem[TXL_W-1:0];
				DOP_PIXSTEP: step_q[POS_W-1:FRAC_W] <= div_rem[TXL_W-1:0];
				default: ;
			endcase
		end
		if (cmd.mul_load) begin
			prod_q <= PROD_W'(offset) * PROD_W'(q_q);
			step_q <= {step_int[TXL_W-1:0], q_q[FRAC_W-1:0]};
			row_q  <= start_row;
			end_q  <= end_row;
		end
		if (cmd.emit) begin
			screen_x_q       <= col_q;
			screen_y_q       <= row_q;
			texture_select_q <= tex_q;
			texel_u_q        <= u_q;
			texel_v_q        <= pos_q[POS_W-1:FRAC_W];
			last_pixel_q     <= last;
			pos_q            <= pos_wrap[POS_W-1:0];
			if (!last) begin
				row_q <= row_q + ROW_W'(1);
			end
		end
	end

	assign status.active   = active_q;
	assign status.div_done = div_done;
	assign status.u_stale  = (tw != u_tw_q);
	assign status.pos_big  = ({1'b0, pos_q[POS_W-1:FRAC_W]} >= th);
	assign status.step_big = ({1'b0, step_q[POS_W-1:FRAC_W]} >= th);
	assign status.out_free = out_free;

	assign out_valid      = out_valid_q;
	assign screen_x       = screen_x_q;
	assign screen_y       = screen_y_q;
	assign texture_select = texture_select_q;
	assign texel_u        = texel_u_q;
	assign texel_v        = texel_v_q;
	assign last_pixel     = last_pixel_q;

endmodule

/* src/rwc_ctrl.sv */
// Controller: sequences column setup and pixel emission over the datapath.
// Depends on rwc_pkg for the command and status structs.
module rwc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 func,
	output logic                 in_ready,
	input  rwc_pkg::rwc_status_t status,
	output rwc_pkg::rwc_cmd_t    cmd
);
	import rwc_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_HDIV  = 10'b0000000010,
		ST_QDIV  = 10'b0000000100,
		ST_MUL   = 10'b0000001000,
		ST_PDIV  = 10'b0000010000,
		ST_UDIV  = 10'b0000100000,
		ST_PCHK  = 10'b0001000000,
		ST_PUDIV = 10'b0010000000,
		ST_PPDIV = 10'b0100000000,
		ST_PSDIV = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   kick_q, kick_d;

	always_comb begin
		state_d         = state_q;
		kick_d          = 1'b0;
		in_ready        = 1'b0;
		cmd             = '0;
		cmd.div_op      = DOP_HEIGHT;
		cmd.div_start   = kick_q;
		cmd.div_capture = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!func) begin
						cmd.load_start = 1'b1;
						state_d        = ST_HDIV;
						kick_d         = 1'b1;
					end else if (status.active) begin
						state_d = ST_PCHK;
					end
				end
			end
			ST_HDIV: begin
				cmd.div_op = DOP_HEIGHT;
				if (status.div_done) begin
					cmd.div_capture = 1'b1;
					state_d         = ST_QDIV;
					kick_d          = 1'b1;
				end
			end
			ST_QDIV: begin
				cmd.div_op = DOP_TSTEP;
				if (status.div_done) begin
					cmd.div_capture = 1'b1;
					state_d         = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = ST_PDIV;
				kick_d       = 1'b1;
			end
			ST_PDIV: begin
				cmd.div_op = DOP_POS;
				if (status.div_done) begin
					cmd.div_capture = 1'b1;
					state_d         = ST_UDIV;
					kick_d          = 1'b1;
				end
			end
			ST_UDIV: begin
				cmd.div_op = DOP_U;
				if (status.div_done) begin
					cmd.div_capture = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			// Sizes changed since the column started are folded in before the beat.
			ST_PCHK: begin
				if (status.u_stale) begin
					state_d = ST_PUDIV;
					kick_d  = 1'b1;
				end else if (status.pos_big) begin
					state_d = ST_PPDIV;
					kick_d  = 1'b1;
				end else if (status.step_big) begin
					state_d = ST_PSDIV;
					kick_d  = 1'b1;
				end else if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_PUDIV: begin
				cmd.div_op = DOP_U;
				if (status.div_done) begin
					cmd.div_capture = 1'b1;
					state_d         = ST_PCHK;
				end
			end
			ST_PPDIV: begin
				cmd.div_op = DOP_PIXPOS;
				if (status.div_done) begin
					cmd.div_capture = 1'b1;
					state_d         = ST_PCHK;
				end
			end
			ST_PSDIV: begin
				cmd.div_op = DOP_PIXSTEP;
				if (status.div_done) begin
					cmd.div_capture = 1'b1;
					state_d         = ST_PCHK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kick_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			kick_q  <= kick_d;
		end
	end

endmodule

/* src/raycast_wall_column_texturer.sv */
// Wall column texturer for a grid raycaster. A pixel beat is accepted in the
// idle state; the controller holds it in the check state until its texel
// coordinates are reduced and the output register is free, writes it to the
// output register and returns to idle, where the next beat can be accepted.
// A start beat runs four divisions through one shared restoring divider that
// produces one quotient bit per cycle, with a DIV_W-bit dividend, where DIV_W =
// max(27, clog2(SCREEN_HEIGHT + 1) + 16). If a texture size register is
// rewritten in the middle of a column, the next pixel beat spends up to three
// more divisions reducing the held texel coordinates. The output register lets
// a new beat be accepted while the previous pixel is still waiting downstream.
module raycast_wall_column_texturer #(
	parameter int SCREEN_HEIGHT = 512
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [rwc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rwc_pkg::TEX_DIM_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [rwc_pkg::COL_W-1:0]     column_x,
	input  logic [rwc_pkg::DIST_W-1:0]    wall_distance,
	input  logic                          hit_side,
	input  logic                          ray_dir_x_positive,
	input  logic                          ray_dir_y_positive,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rwc_pkg::COL_W-1:0]     screen_x,
	output logic [rwc_pkg::ROW_W-1:0]     screen_y,
	output logic [rwc_pkg::SEL_W-1:0]     texture_select,
	output logic [rwc_pkg::TXL_W-1:0]     texel_u,
	output logic [rwc_pkg::TXL_W-1:0]     texel_v,
	output logic                          last_pixel
);
	import rwc_pkg::*;

	rwc_cmd_t    cmd;
	rwc_status_t status;

	rwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rwc_datapath #(
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.column_x           (column_x),
		.wall_distance      (wall_distance),
		.hit_side           (hit_side),
		.ray_dir_x_positive (ray_dir_x_positive),
		.ray_dir_y_positive (ray_dir_y_positive),
		.cmd                (cmd),
		.status             (status),
		.out_ready          (out_ready),
		.out_valid          (out_valid),
		.screen_x           (screen_x),
		.screen_y           (screen_y),
		.texture_select     (texture_select),
		.texel_u            (texel_u),
		.texel_v            (texel_v),
		.last_pixel         (last_pixel)
	);

`ifndef SYNTHESIS
	// A pixel is only emitted once its texel coordinates are reduced and the
	// output register can take it.
	a_emit_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (status.out_free && !status.u_stale && !status.pos_big
			&& !status.step_big))
		else $error("pixel emitted with unreduced coordinates or full output");

	a_row_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, screen_y} < (ROW_W + 1)'(SCREEN_HEIGHT)))
		else $error("emitted row lies below the screen");

	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !status.div_done)
		else $error("divider finished in the cycle after its start");
`endif

endmodule
